// ===== hdl/tkd_pkg.sv =====
// ----------------------------------------------------------------------------
// tkd_pkg
// Types, codes and key tables shared by the terminal escape key decoder.
// ----------------------------------------------------------------------------
package tkd_pkg;

  localparam logic [7:0]  CH_ESC    = 8'h1b;
  localparam logic [7:0]  CH_CSI    = 8'h9b;
  localparam logic [7:0]  CH_SS3    = 8'h8f;
  localparam logic [7:0]  CH_LBRACK = 8'h5b;
  localparam logic [7:0]  CH_O      = 8'h4f;
  localparam logic [7:0]  CH_SEMI   = 8'h3b;
  localparam logic [7:0]  CH_TILDE  = 8'h7e;
  localparam logic [7:0]  CH_U      = 8'h75;
  localparam logic [7:0]  CH_M      = 8'h4d;
  localparam logic [7:0]  CH_Z      = 8'h5a;
  localparam logic [20:0] ARG_ABSENT = 21'h1fffff;
  localparam logic [20:0] ARG_CAP    = 21'h1ffffe;
  localparam logic [20:0] CP_ARG     = 21'd27;
  localparam logic [20:0] FUNC_DEPTH = 21'd35;
  localparam logic [7:0]  MOD_SHIFT  = 8'h01;
  localparam logic [7:0]  MOD_ALT    = 8'h02;

  typedef enum logic [1:0] {
    ST_KEY     = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_PASS    = 2'd2,
    ST_MOUSE   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KK_CODEPOINT = 2'd0,
    KK_KEYSYM    = 2'd1,
    KK_FUNC      = 2'd2
  } key_kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_SEQ  = 2'd2
  } mode_t;

  typedef struct packed {
    status_t     status;
    key_kind_t   kind;
    logic [20:0] code;
    logic [7:0]  mods;
    logic [7:0]  raw;
  } res_t;

  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } entry_t;

  // table entry: valid, function key flag, number
  typedef struct packed {
    logic       valid;
    logic       fn;
    logic [7:0] num;
  } tab_t;

  localparam res_t RES_ZERO = '{status: ST_KEY, kind: KK_CODEPOINT,
                                code: '0, mods: '0, raw: '0};

  function automatic tab_t sym(input logic [7:0] n);
    sym = '{valid: 1'b1, fn: 1'b0, num: n};
  endfunction

  function automatic tab_t fnk(input logic [7:0] n);
    fnk = '{valid: 1'b1, fn: 1'b1, num: n};
  endfunction

  function automatic tab_t func_rom(input logic [5:0] idx);
    tab_t t;
    t = '0;
    case (idx)
      6'd1:  t = sym(8'd26);
      6'd2:  t = sym(8'd27);
      6'd3:  t = sym(8'd28);
      6'd4:  t = sym(8'd29);
      6'd5:  t = sym(8'd30);
      6'd6:  t = sym(8'd31);
      6'd7:  t = sym(8'd6);
      6'd8:  t = sym(8'd5);
      6'd11: t = fnk(8'd1);
      6'd12: t = fnk(8'd2);
      6'd13: t = fnk(8'd3);
      6'd14: t = fnk(8'd4);
      6'd15: t = fnk(8'd5);
      6'd17: t = fnk(8'd6);
      6'd18: t = fnk(8'd7);
      6'd19: t = fnk(8'd8);
      6'd20: t = fnk(8'd9);
      6'd21: t = fnk(8'd10);
      6'd23: t = fnk(8'd11);
      6'd24: t = fnk(8'd12);
      6'd25: t = fnk(8'd13);
      6'd26: t = fnk(8'd14);
      6'd28: t = fnk(8'd15);
      6'd29: t = fnk(8'd16);
      6'd31: t = fnk(8'd17);
      6'd32: t = fnk(8'd18);
      6'd33: t = fnk(8'd19);
      6'd34: t = fnk(8'd20);
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic tab_t shared_rom(input logic [7:0] c);
    tab_t t;
    t = '0;
    case (c)
      8'h41: t = sym(8'd0);
      8'h42: t = sym(8'd1);
      8'h43: t = sym(8'd2);
      8'h44: t = sym(8'd3);
      8'h45: t = sym(8'd4);
      8'h46: t = sym(8'd5);
      8'h48: t = sym(8'd6);
      8'h50: t = fnk(8'd1);
      8'h51: t = fnk(8'd2);
      8'h52: t = fnk(8'd3);
      8'h53: t = fnk(8'd4);
      8'h5a: t = sym(8'd7);
      default: t = '0;
    endcase
    return t;
  endfunction

  // keypad: bits 15:8 ascii alternative, bits 7:0 keysym, 0 means none
  function automatic logic [15:0] keypad_rom(input logic [7:0] c);
    logic [15:0] k;
    k = '0;
    case (c)
      8'h4d: k = {8'h00, 8'd8};
      8'h58: k = {8'h3d, 8'd9};
      8'h6a: k = {8'h2a, 8'd10};
      8'h6b: k = {8'h2b, 8'd11};
      8'h6c: k = {8'h2c, 8'd12};
      8'h6d: k = {8'h2d, 8'd13};
      8'h6e: k = {8'h2e, 8'd14};
      8'h6f: k = {8'h2f, 8'd15};
      8'h70: k = {8'h30, 8'd16};
      8'h71: k = {8'h31, 8'd17};
      8'h72: k = {8'h32, 8'd18};
      8'h73: k = {8'h33, 8'd19};
      8'h74: k = {8'h34, 8'd20};
      8'h75: k = {8'h35, 8'd21};
      8'h76: k = {8'h36, 8'd22};
      8'h77: k = {8'h37, 8'd23};
      8'h78: k = {8'h38, 8'd24};
      8'h79: k = {8'h39, 8'd25};
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

// ===== hdl/tkd_front.sv =====
// ----------------------------------------------------------------------------
// tkd_front
// Byte parser: tracks escape state, collects arguments and decodes finals
// into one queue entry of up to two results per input beat.
// ----------------------------------------------------------------------------
module tkd_front
  import tkd_pkg::*;
#(
  parameter int MAX_ARGS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       convert_keypad,
  input  logic       take,
  input  logic       flush,
  input  logic [7:0] data_byte,
  output logic       push,
  output entry_t     push_entry
);

  localparam int IDX_W = $clog2(MAX_ARGS + 1);

  mode_t             mode_r, mode_nxt;
  logic              ss3_r, ss3_nxt;
  logic [20:0]       arg_r [3];
  logic [20:0]       arg_nxt [3];
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              ds_r, ds_nxt;

  logic [7:0]  mod_csi;
  logic [24:0] acc;
  logic [20:0] acc_base;
  tab_t        ent;
  logic [15:0] kp;
  res_t        csi_res, ss3_res, r0, r1;
  logic        any, two;

  function automatic res_t key_of(input tab_t t, input logic [7:0] m);
    res_t r;
    r = RES_ZERO;
    if (!t.valid) begin
      r.status = ST_UNKNOWN;
    end else begin
      r.kind = t.fn ? KK_FUNC : KK_KEYSYM;
      r.code = {13'd0, t.num};
      r.mods = m;
    end
    return r;
  endfunction

  function automatic res_t pass_of(input logic [7:0] b);
    res_t r;
    r = RES_ZERO;
    r.status = ST_PASS;
    r.raw = b;
    return r;
  endfunction

  function automatic res_t cp_of(input logic [20:0] c, input logic [7:0] m);
    res_t r;
    r = RES_ZERO;
    r.code = c;
    r.mods = m;
    return r;
  endfunction

  // csi final decode
  always_comb begin
    mod_csi = (arg_r[1] == ARG_ABSENT) ? 8'd0 : arg_r[1][7:0] - 8'd1;
    ent = '0;
    csi_res = RES_ZERO;
    if (data_byte == CH_TILDE) begin
      if (arg_r[0] == CP_ARG) begin
        csi_res = cp_of(arg_r[2], mod_csi);
      end else begin
        if (arg_r[0] < FUNC_DEPTH) ent = func_rom(arg_r[0][5:0]);
        csi_res = key_of(ent, mod_csi);
      end
    end else if (data_byte == CH_U) begin
      csi_res = cp_of(arg_r[0], mod_csi);
    end else if (data_byte == CH_M) begin
      csi_res.status = ST_MOUSE;
    end else begin
      csi_res = key_of(shared_rom(data_byte),
                       (data_byte == CH_Z) ? (mod_csi | MOD_SHIFT) : mod_csi);
    end
  end

  // ss3 final decode
  always_comb begin
    kp = keypad_rom(data_byte);
    ss3_res = RES_ZERO;
    if (data_byte[7:6] != 2'b01) begin
      ss3_res.status = ST_UNKNOWN;
    end else if (shared_rom(data_byte).valid) begin
      ss3_res = key_of(shared_rom(data_byte),
                       (data_byte == CH_Z) ? MOD_SHIFT : 8'd0);
    end else if (kp == 16'd0) begin
      ss3_res.status = ST_UNKNOWN;
    end else if (convert_keypad && kp[15:8] != 8'd0) begin
      ss3_res = cp_of({13'd0, kp[15:8]}, 8'd0);
    end else begin
      ss3_res.kind = KK_KEYSYM;
      ss3_res.code = {13'd0, kp[7:0]};
    end
  end

  // decimal accumulate, v*10 + digit with saturation
  always_comb begin
    acc_base = ds_r ? arg_r[idx_r[1:0]] : 21'd0;
    acc = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0}
        + {21'd0, data_byte[3:0]};
  end

  always_comb begin
    mode_nxt = mode_r;
    ss3_nxt  = ss3_r;
    arg_nxt  = arg_r;
    idx_nxt  = idx_r;
    ds_nxt   = ds_r;
    r0  = RES_ZERO;
    r1  = RES_ZERO;
    any = 1'b0;
    two = 1'b0;
    if (flush) begin
      if (mode_r == MODE_ESC) begin
        r0  = pass_of(CH_ESC);
        any = 1'b1;
      end else if (mode_r == MODE_SEQ) begin
        r0  = cp_of({13'd0, ss3_r ? CH_O : CH_LBRACK}, MOD_ALT);
        any = 1'b1;
      end
      mode_nxt = MODE_IDLE;
      ss3_nxt  = 1'b0;
      arg_nxt  = '{ARG_ABSENT, ARG_ABSENT, ARG_ABSENT};
      idx_nxt  = '0;
      ds_nxt   = 1'b0;
    end else begin
      case (mode_r)
        MODE_ESC: begin
          if (data_byte == CH_LBRACK || data_byte == CH_O) begin
            mode_nxt = MODE_SEQ;
            ss3_nxt  = (data_byte == CH_O);
            arg_nxt  = '{ARG_ABSENT, ARG_ABSENT, ARG_ABSENT};
            idx_nxt  = '0;
            ds_nxt   = 1'b0;
          end else begin
            r0  = pass_of(CH_ESC);
            any = 1'b1;
            mode_nxt = MODE_IDLE;
            if (data_byte == CH_ESC) begin
              mode_nxt = MODE_ESC;
            end else if (data_byte == CH_CSI || data_byte == CH_SS3) begin
              mode_nxt = MODE_SEQ;
              ss3_nxt  = (data_byte == CH_SS3);
              arg_nxt  = '{ARG_ABSENT, ARG_ABSENT, ARG_ABSENT};
              idx_nxt  = '0;
              ds_nxt   = 1'b0;
            end else begin
              r1  = pass_of(data_byte);
              two = 1'b1;
            end
          end
        end
        MODE_SEQ: begin
          if (ss3_r || data_byte[7:6] == 2'b01) begin
            r0  = ss3_r ? ss3_res : csi_res;
            any = 1'b1;
            mode_nxt = MODE_IDLE;
            ss3_nxt  = 1'b0;
            arg_nxt  = '{ARG_ABSENT, ARG_ABSENT, ARG_ABSENT};
            idx_nxt  = '0;
            ds_nxt   = 1'b0;
          end else if (idx_r < IDX_W'(MAX_ARGS)) begin
            if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
              if (idx_r < IDX_W'(3)) begin
                arg_nxt[idx_r[1:0]] = (acc > {4'd0, ARG_CAP}) ? ARG_CAP : acc[20:0];
              end
              ds_nxt = 1'b1;
            end else if (data_byte == CH_SEMI) begin
              idx_nxt = idx_r + IDX_W'(1);
              ds_nxt  = 1'b0;
            end
          end
        end
        default: begin
          if (data_byte == CH_ESC) begin
            mode_nxt = MODE_ESC;
          end else if (data_byte == CH_CSI || data_byte == CH_SS3) begin
            mode_nxt = MODE_SEQ;
            ss3_nxt  = (data_byte == CH_SS3);
            arg_nxt  = '{ARG_ABSENT, ARG_ABSENT, ARG_ABSENT};
            idx_nxt  = '0;
            ds_nxt   = 1'b0;
          end else begin
            r0  = pass_of(data_byte);
            any = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      ss3_r  <= 1'b0;
      arg_r  <= '{ARG_ABSENT, ARG_ABSENT, ARG_ABSENT};
      idx_r  <= '0;
      ds_r   <= 1'b0;
    end else if (take) begin
      mode_r <= mode_nxt;
      ss3_r  <= ss3_nxt;
      arg_r  <= arg_nxt;
      idx_r  <= idx_nxt;
      ds_r   <= ds_nxt;
    end
  end

  assign push       = take && any;
  assign push_entry = '{r0: r0, r1: r1, two: two};

`ifndef SYNTHESIS
  a_args_clear_outside_seq: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != MODE_SEQ |-> (idx_r == '0 && !ds_r && arg_r[0] == ARG_ABSENT))
    else $error("argument state not cleared outside a sequence");
  a_ss3_only_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
    ss3_r |-> mode_r == MODE_SEQ)
    else $error("ss3 flag set outside a sequence");
  a_flush_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    take && flush |=> mode_r == MODE_IDLE)
    else $error("flush did not return parser to idle");
`endif

endmodule

// ===== hdl/tkd_queue.sv =====
// ----------------------------------------------------------------------------
// tkd_queue
// Two-entry queue of decoded result pairs between parser and output stage.
// ----------------------------------------------------------------------------
module tkd_queue
  import tkd_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   empty,
  output logic   full
);

  entry_t     q_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign head  = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue count out of range");
`endif

endmodule

// ===== hdl/tkd_back.sv =====
// ----------------------------------------------------------------------------
// tkd_back
// Output stage: splits each queue entry into one or two result beats and
// holds them in an output register.
// ----------------------------------------------------------------------------
module tkd_back
  import tkd_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  entry_t head,
  input  logic   empty,
  output logic   pop,
  output logic   out_valid,
  input  logic   out_ready,
  output res_t   out_res,
  output logic   out_last
);

  logic valid_r, valid_nxt;
  logic half_r, half_nxt;
  res_t res_r, res_nxt;
  logic last_r, last_nxt;
  logic load;

  assign load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r && !out_ready;
    half_nxt  = half_r;
    res_nxt   = res_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    if (load) begin
      if (half_r) begin
        // second result of a pair
        valid_nxt = 1'b1;
        res_nxt   = head.r1;
        last_nxt  = 1'b1;
        half_nxt  = 1'b0;
        pop       = 1'b1;
      end else if (!empty) begin
        valid_nxt = 1'b1;
        res_nxt   = head.r0;
        last_nxt  = !head.two;
        half_nxt  = head.two;
        pop       = !head.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      half_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      half_r  <= half_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;
  assign out_last  = last_r;

`ifndef SYNTHESIS
  a_half_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    half_r |-> !empty)
    else $error("pending second result without queue entry");
  a_half_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    half_r |-> (valid_r && !last_r))
    else $error("first result of a pair marked last");
`endif

endmodule

// ===== hdl/terminal_escape_key_decoder.sv =====
// ----------------------------------------------------------------------------
// terminal_escape_key_decoder
// Terminal byte stream to key events: CSI/SS3 parsing, argument collection,
// final-byte decode and passthrough.
// ----------------------------------------------------------------------------
// One input beat is accepted per clock while the two-entry result queue has
// room; each beat yields zero, one or two result beats. The output stage
// delivers one result beat per clock while out_tready is high; a beat that
// yields two results (a lone ESC then an ordinary byte) gives two output
// beats; otherwise one input beat per cycle is sustained while out_tready is
// high. Results pass the queue, then the output register. Configuration is
// accepted at any time and must only be written while the block is idle.
module terminal_escape_key_decoder
  import tkd_pkg::*;
#(
  parameter int MAX_ARGS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_data,     // convert_keypad
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // data_byte
  input  logic        in_tuser,     // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,    // key_kind, key_code, modifiers, raw_byte, pad
  output logic [1:0]  out_tuser,    // status
  output logic        out_tlast     // last
);

  logic   convert_keypad_r;
  logic   take, push, pop, empty, full;
  entry_t push_entry, head;
  res_t   res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      convert_keypad_r <= 1'b0;
    end else if (cfg_valid) begin
      convert_keypad_r <= cfg_data[0];
    end
  end

  assign in_tready = !full;
  assign take      = in_tvalid && !full;

  tkd_front #(.MAX_ARGS(MAX_ARGS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .convert_keypad(convert_keypad_r),
    .take          (take),
    .flush         (in_tuser),
    .data_byte     (in_tdata),
    .push          (push),
    .push_entry    (push_entry)
  );

  tkd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  tkd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (res),
    .out_last (out_tlast)
  );

  assign out_tdata = {1'b0, res.raw, res.mods, res.code, res.kind};
  assign out_tuser = res.status;

endmodule
